// ===== hdl/lfts_pkg.sv =====
// Package for the letter frequency text statistics block.
// Holds widths, character codes and the controller command/status types.
package lfts_pkg;
    localparam int COUNT_BITS  = 24;
    localparam int LETTER_BINS = 26;
    localparam int LETTER_BITS = 5;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [LETTER_BITS-1:0] LAST_LETTER = LETTER_BITS'(LETTER_BINS - 1);

    localparam logic [7:0] CHAR_UNDERSCORE = 8'd95;
    localparam logic [7:0] CHAR_SEMICOLON  = 8'd59;
    localparam logic [7:0] CHAR_COMMA      = 8'd44;
    localparam logic [7:0] CHAR_PERIOD     = 8'd46;
    localparam logic [7:0] CHAR_QUESTION   = 8'd63;

    typedef enum logic [3:0] {
        ST_COUNT = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_EMIT  = 4'b0100,
        ST_CLEAR = 4'b1000
    } lfts_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic count_en;   // Accept and count the input byte.
        logic scan_en;    // Select step: pick the best remaining letter.
        logic scan_start; // Reset the pick for a new scan.
        logic emit_load;  // Load the picked letter into the output register.
        logic clear;      // Clear all counts.
    } lfts_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic out_busy;   // Output register holds an untaken item.
    } lfts_stat_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
    endfunction
endpackage

// ===== hdl/lfts_ctrl.sv =====
// Controller state machine for the letter statistics block.
// Depends on lfts_pkg.
module lfts_ctrl
    import lfts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic       in_last,
    input  lfts_stat_t stat,
    output logic       in_ready,
    output lfts_cmd_t  cmd,
    output logic       emit_final
);
    lfts_state_t state_reg, state_next;
    logic [LETTER_BITS-1:0] scan_reg, scan_next;   // Letter under test in a scan.
    logic [LETTER_BITS-1:0] rank_reg, rank_next;   // Output position.

    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        rank_next  = rank_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_COUNT:
            begin
                in_ready     = 1'b1;
                cmd.count_en = in_fire;
                if (in_fire && in_last)
                begin
                    state_next = ST_SCAN;
                    scan_next  = '0;
                    rank_next  = '0;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_en    = 1'b1;
                cmd.scan_start = (scan_reg == '0);
                if (scan_reg == LAST_LETTER)
                    state_next = ST_EMIT;
                else
                    scan_next = scan_reg + 1'b1;
            end
            ST_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit_load = 1'b1;
                    scan_next     = '0;
                    if (rank_reg == LAST_LETTER)
                        state_next = ST_CLEAR;
                    else
                    begin
                        rank_next  = rank_reg + 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_CLEAR:
            begin
                cmd.clear  = 1'b1;
                state_next = ST_COUNT;
            end
            default:
                state_next = ST_COUNT;
        endcase
    end

    assign emit_final = (rank_reg == LAST_LETTER);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COUNT;
            scan_reg  <= '0;
            rank_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            rank_reg  <= rank_next;
        end
    end

    // Controller's letter index must stay in range.
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg <= LAST_LETTER) else $error("scan index out of range");
    a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
        rank_reg <= LAST_LETTER) else $error("rank out of range");
    a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_COUNT) |-> !in_ready) else $error("ready outside count");
    a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> (state_reg == ST_COUNT)) else $error("clear stuck");
endmodule

// ===== hdl/lfts_dp.sv =====
// Datapath: histogram, totals, selection scan and output register.
// Depends on lfts_pkg.
module lfts_dp
    import lfts_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lfts_cmd_t              cmd,
    input  logic                   emit_final,
    input  logic [7:0]             text_byte,
    input  logic                   out_take,
    output lfts_stat_t             stat,
    output logic                   out_valid,
    output logic [LETTER_BITS-1:0] o_code,
    output logic [COUNT_BITS-1:0]  o_count,
    output logic [COUNT_BITS-1:0]  o_alpha,
    output logic [COUNT_BITS-1:0]  o_marks,
    output logic [COUNT_BITS-1:0]  o_words,
    output logic [LETTER_BITS-1:0] o_most,
    output logic [LETTER_BITS-1:0] o_least,
    output logic                   o_final
);
    logic [COUNT_BITS-1:0] cnt_reg [LETTER_BINS];
    logic [LETTER_BINS-1:0] done_reg;              // Letters already emitted.
    logic [COUNT_BITS-1:0] alpha_reg, mark_reg, word_reg;
    logic inword_reg;
    logic [LETTER_BITS-1:0] scan_reg;              // Local scan index.
    logic [LETTER_BITS-1:0] best_reg, most_reg, least_reg;
    logic [COUNT_BITS-1:0] best_cnt_reg;
    logic best_ok_reg;
    logic out_valid_reg;

    logic [7:0] lb;
    logic is_alpha, is_mark, is_blank;
    logic [LETTER_BITS-1:0] lidx;
    logic [COUNT_BITS-1:0] cur;
    logic better, fresh;

    always_comb
    begin
        lb = ((text_byte >= 8'h41) && (text_byte <= 8'h5A)) ? text_byte + 8'd32 : text_byte;
        is_alpha = (lb >= 8'h61) && (lb <= 8'h7A);
        lidx     = LETTER_BITS'(lb - 8'h61);
        is_mark  = (lb == CHAR_UNDERSCORE) || (lb == CHAR_SEMICOLON) ||
                   (lb == CHAR_COMMA) || (lb == CHAR_PERIOD) || (lb == CHAR_QUESTION);
        is_blank = (lb == 8'd32) || ((lb >= 8'd9) && (lb <= 8'd13));
        cur      = cnt_reg[scan_reg];
        fresh    = cmd.scan_start || !best_ok_reg;
        // Scanning upward, a higher letter wins ties.
        better   = !done_reg[scan_reg] && (fresh || (cur >= best_cnt_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LETTER_BINS; k++)
                cnt_reg[k] <= '0;
            done_reg      <= '0;
            alpha_reg     <= '0;
            mark_reg      <= '0;
            word_reg      <= '0;
            inword_reg    <= 1'b0;
            scan_reg      <= '0;
            best_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.count_en)
            begin
                if (is_alpha)
                begin
                    alpha_reg     <= sat_inc(alpha_reg);
                    cnt_reg[lidx] <= sat_inc(cnt_reg[lidx]);
                end
                if (is_mark)
                    mark_reg <= sat_inc(mark_reg);
                if (is_blank)
                    inword_reg <= 1'b0;
                else if (!inword_reg)
                begin
                    inword_reg <= 1'b1;
                    word_reg   <= sat_inc(word_reg);
                end
            end
            if (cmd.scan_en)
            begin
                scan_reg <= (scan_reg == LAST_LETTER) ? '0 : scan_reg + 1'b1;
                if (cmd.scan_start)
                    best_ok_reg <= 1'b0;
                if (better)
                begin
                    best_ok_reg  <= 1'b1;
                    best_reg     <= scan_reg;
                    best_cnt_reg <= cur;
                end
            end
            if (out_take)
                out_valid_reg <= 1'b0;
            if (cmd.emit_load)
            begin
                out_valid_reg      <= 1'b1;
                done_reg[best_reg] <= 1'b1;
                best_ok_reg        <= 1'b0;
            end
            if (cmd.clear)
            begin
                for (int k = 0; k < LETTER_BINS; k++)
                    cnt_reg[k] <= '0;
                done_reg   <= '0;
                alpha_reg  <= '0;
                mark_reg   <= '0;
                word_reg   <= '0;
                inword_reg <= 1'b0;
            end
        end
    end

    // Most/least: first index on ties, found with the first sort pass.
    logic [LETTER_BITS-1:0] most_d, least_d;
    always_comb
    begin
        most_d  = cmd.scan_start ? '0 : most_reg;
        least_d = cmd.scan_start ? '0 : least_reg;
        if (!cmd.scan_start)
        begin
            if (cur > cnt_reg[most_reg])
                most_d = scan_reg;
            if (cur < cnt_reg[least_reg])
                least_d = scan_reg;
        end
    end

    logic first_pass_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            first_pass_reg <= 1'b1;
        else if (cmd.emit_load)
            first_pass_reg <= 1'b0;
        else if (cmd.clear)
            first_pass_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_en && first_pass_reg)
        begin
            most_reg  <= most_d;
            least_reg <= least_d;
        end
        if (cmd.emit_load)
        begin
            o_code  <= best_reg;
            o_count <= best_cnt_reg;
            o_alpha <= alpha_reg;
            o_marks <= ((COUNT_BITS+1)'(alpha_reg) + (COUNT_BITS+1)'(mark_reg) >
                        (COUNT_BITS+1)'(COUNT_MAX))
                       ? COUNT_MAX : alpha_reg + mark_reg;
            o_words <= word_reg;
            o_most  <= most_reg;
            o_least <= least_reg;
            o_final <= emit_final;
        end
    end

    assign out_valid     = out_valid_reg;
    assign stat.out_busy = out_valid_reg && !out_take;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> !(out_valid_reg && !out_take)) else $error("output overwritten");
    a_pick_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> !done_reg[best_reg]) else $error("letter emitted twice");
endmodule

// ===== hdl/letter_frequency_text_stats.sv =====
// Letter frequency text statistics, top level.
// After the final byte the 26 sorted items leave one at a time, each after a selection
// pass over the 26 counts; an item waits while the output register is still held.
// Throughput: one text byte per cycle while counting; a clear step follows a run.
// Reset: rst_n is asynchronous, active low; it clears all counts and the controller.
// Depends on lfts_pkg, lfts_ctrl and lfts_dp.
module letter_frequency_text_stats
    import lfts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [111:0] m_tdata,  // letter_code, letter_count, alpha_total,
                                   // letters_and_marks, word_total, most_frequent,
                                   // least_frequent, zero fill
    output logic        m_tlast    // final_entry
);
    lfts_cmd_t  cmd;
    lfts_stat_t stat;
    logic emit_final;
    logic [LETTER_BITS-1:0] o_code, o_most, o_least;
    logic [COUNT_BITS-1:0] o_count, o_alpha, o_marks, o_words;

    lfts_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(s_tvalid && s_tready), .in_last(s_tlast),
        .stat(stat), .in_ready(s_tready), .cmd(cmd), .emit_final(emit_final)
    );

    lfts_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .emit_final(emit_final),
        .text_byte(s_tdata), .out_take(m_tvalid && m_tready), .stat(stat),
        .out_valid(m_tvalid), .o_code(o_code), .o_count(o_count), .o_alpha(o_alpha),
        .o_marks(o_marks), .o_words(o_words), .o_most(o_most), .o_least(o_least),
        .o_final(m_tlast)
    );

    assign m_tdata = {1'b0, o_least, o_most, o_words, o_marks, o_alpha, o_count, o_code};
endmodule
